### rtl/ncpa_pkg.sv
// Package for the NFC credential presence authorization block.
// Holds the transaction structs, register and event codes, and the UID byte mask.
// No dependencies.
package ncpa_pkg;

    localparam int unsigned UID_BYTES   = 7;
    localparam int unsigned UID_W       = 56;
    localparam int unsigned UID_LEN_W   = 4;
    localparam int unsigned AUTH_LEN_W  = 3;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_DATA_W  = 56;

    localparam logic [UID_LEN_W-1:0]  UID_LEN_MAX      = UID_LEN_W'(UID_BYTES);
    localparam logic [AUTH_LEN_W-1:0] AUTH_LEN_RESET   = 3'd4;
    localparam logic [TIME_W-1:0]     GRACE_MS_RESET   = 32'd1000;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SUCCESS = 2'd1;
    localparam logic [1:0] EV_FAILED  = 2'd2;
    localparam logic [1:0] EV_LOST    = 2'd3;

    typedef enum logic [1:0] {
        CFG_READER_OPERATIONAL,
        CFG_AUTHORIZED_UID,
        CFG_AUTHORIZED_UID_LENGTH,
        CFG_GRACE_PERIOD_MS
    } cfg_index_t;

    typedef struct packed {
        logic                  card_detected;
        logic [UID_LEN_W-1:0]  uid_length;
        logic [UID_W-1:0]      uid_bytes;
        logic [TIME_W-1:0]     now_ms;
    } poll_t;

    typedef struct packed {
        logic       is_authorized;
        logic [1:0] auth_event;
        logic       new_uid_seen;
    } result_t;

    // keep the low len bytes of the UID field
    function automatic logic [UID_W-1:0] byte_mask(input logic [UID_LEN_W-1:0] len);
        logic [UID_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < UID_W / 8; i++)
        begin
            mask[i*8 +: 8] = (UID_LEN_W'(i) < len) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

### rtl/nfc_credential_presence_auth.sv
// Top level of the NFC credential presence authorization block.
// Depends on ncpa_pkg for transaction structs, codes and the byte mask.
//
//  channel | signals                               | direction
//  poll    | poll_valid, poll_ready, poll          | reader poll in
//  result  | result_valid, result_ready, result    | one result out per poll
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes in
//
// One poll per cycle while the result is not stalled; a poll's result passes through the
// input register, then the result register, and is then offered on the result channel.
// State updates as the result loads.
// Reset clears configuration to its defaults and all card and authorization
// state. A stalled result holds the input register; cfg_ready is always high.
module nfc_credential_presence_auth (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 poll_valid,
    output logic                                 poll_ready,
    input  ncpa_pkg::poll_t                      poll,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ncpa_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  ncpa_pkg::cfg_index_t                 cfg_index,
    input  logic [ncpa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ncpa_pkg::*;

    // configuration
    logic                  reader_operational_reg;
    logic [UID_W-1:0]      authorized_uid_reg;
    logic [AUTH_LEN_W-1:0] authorized_uid_length_reg;
    logic [TIME_W-1:0]     grace_period_ms_reg;

    // pipeline
    logic                  poll_valid_reg;
    poll_t                 poll_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    // card and authorization state
    logic                  card_observed_reg, card_observed_next;
    logic                  auth_held_reg, auth_held_next;
    logic                  auth_time_valid_reg, auth_time_valid_next;
    logic [TIME_W-1:0]     last_auth_seen_ms_reg, last_auth_seen_ms_next;
    logic [TIME_W-1:0]     last_card_seen_ms_reg, last_card_seen_ms_next;
    logic [UID_W-1:0]      prev_uid_reg, prev_uid_next;
    logic [AUTH_LEN_W-1:0] prev_uid_length_reg, prev_uid_length_next;
    result_t               result_next;

    logic                  result_load;
    logic                  advance;
    logic                  valid_card;
    logic [UID_W-1:0]      mask;
    logic [UID_W-1:0]      cur_uid;
    logic [AUTH_LEN_W-1:0] len3;
    logic                  same_as_prev;
    logic                  matches_auth;
    logic                  new_uid;
    logic [TIME_W-1:0]     card_age;
    logic [TIME_W-1:0]     auth_age;

    assign result_load  = !result_valid_reg || result_ready;
    assign advance      = poll_valid_reg && result_load;
    assign poll_ready   = !poll_valid_reg || result_load;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    assign valid_card   = poll_reg.card_detected && (poll_reg.uid_length != '0)
                          && (poll_reg.uid_length <= UID_LEN_MAX);
    assign mask         = byte_mask(poll_reg.uid_length);
    assign cur_uid      = poll_reg.uid_bytes & mask;
    assign len3         = poll_reg.uid_length[AUTH_LEN_W-1:0];
    assign same_as_prev = (len3 == prev_uid_length_reg) && (cur_uid == (prev_uid_reg & mask));
    assign matches_auth = (len3 == authorized_uid_length_reg)
                          && (cur_uid == (authorized_uid_reg & mask));
    assign new_uid      = !card_observed_reg || !same_as_prev;
    assign card_age     = poll_reg.now_ms - last_card_seen_ms_reg;
    assign auth_age     = poll_reg.now_ms - last_auth_seen_ms_reg;

    always_comb
    begin
        card_observed_next     = card_observed_reg;
        auth_held_next         = auth_held_reg;
        auth_time_valid_next   = auth_time_valid_reg;
        last_auth_seen_ms_next = last_auth_seen_ms_reg;
        last_card_seen_ms_next = last_card_seen_ms_reg;
        prev_uid_next          = prev_uid_reg;
        prev_uid_length_next   = prev_uid_length_reg;
        result_next            = '0;
        result_next.auth_event = EV_NONE;

        if (!reader_operational_reg)
        begin
            auth_held_next = 1'b0;
        end
        else if (valid_card)
        begin
            card_observed_next     = 1'b1;
            last_card_seen_ms_next = poll_reg.now_ms;
            result_next.new_uid_seen = new_uid;
            if (new_uid)
            begin
                prev_uid_next        = cur_uid;
                prev_uid_length_next = len3;
            end
            if (matches_auth)
            begin
                last_auth_seen_ms_next = poll_reg.now_ms;
                auth_time_valid_next   = 1'b1;
                auth_held_next         = 1'b1;
                if (!auth_held_reg)
                begin
                    result_next.auth_event = EV_SUCCESS;
                end
            end
            else
            begin
                auth_held_next       = 1'b0;
                auth_time_valid_next = 1'b0;
                if (new_uid || auth_held_reg)
                begin
                    result_next.auth_event = EV_FAILED;
                end
            end
        end
        else
        begin
            if (card_observed_reg && (card_age >= grace_period_ms_reg))
            begin
                card_observed_next   = 1'b0;
                prev_uid_length_next = '0;
            end
            if (auth_held_reg && auth_time_valid_reg && (auth_age >= grace_period_ms_reg))
            begin
                auth_held_next         = 1'b0;
                auth_time_valid_next   = 1'b0;
                result_next.auth_event = EV_LOST;
            end
        end

        result_next.is_authorized = reader_operational_reg && auth_held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reader_operational_reg    <= 1'b0;
            authorized_uid_reg        <= '0;
            authorized_uid_length_reg <= AUTH_LEN_RESET;
            grace_period_ms_reg       <= GRACE_MS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_READER_OPERATIONAL:    reader_operational_reg    <= cfg_data[0];
                CFG_AUTHORIZED_UID:        authorized_uid_reg        <= cfg_data[UID_W-1:0];
                CFG_AUTHORIZED_UID_LENGTH: authorized_uid_length_reg <= cfg_data[AUTH_LEN_W-1:0];
                CFG_GRACE_PERIOD_MS:       grace_period_ms_reg       <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (poll_ready)
        begin
            poll_valid_reg <= poll_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_ready && poll_valid)
        begin
            poll_reg <= poll;
        end
    end

    // result register and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg      <= 1'b0;
            card_observed_reg     <= 1'b0;
            auth_held_reg         <= 1'b0;
            auth_time_valid_reg   <= 1'b0;
            last_auth_seen_ms_reg <= '0;
            last_card_seen_ms_reg <= '0;
            prev_uid_reg          <= '0;
            prev_uid_length_reg   <= '0;
        end
        else if (advance)
        begin
            result_valid_reg      <= 1'b1;
            card_observed_reg     <= card_observed_next;
            auth_held_reg         <= auth_held_next;
            auth_time_valid_reg   <= auth_time_valid_next;
            last_auth_seen_ms_reg <= last_auth_seen_ms_next;
            last_card_seen_ms_reg <= last_card_seen_ms_next;
            prev_uid_reg          <= prev_uid_next;
            prev_uid_length_reg   <= prev_uid_length_next;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### rtl/ncpa_checker.sv
// Port-level checks for the NFC credential presence authorization block.
// Depends on ncpa_pkg; bound to nfc_credential_presence_auth below.
module ncpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                poll_valid,
    input logic                poll_ready,
    input logic                result_valid,
    input logic                result_ready,
    input ncpa_pkg::result_t   result
);
    import ncpa_pkg::*;

    // hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // a poll back-pressures only behind a stalled result
    a_poll_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !poll_ready |-> result_valid && !result_ready)
        else $error("poll stalled without a stalled result");

    // an accepted poll has a result waiting once it has passed the input and result registers
    a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
        poll_valid && poll_ready |=> ##1 result_valid)
        else $error("accepted poll produced no result");

    // success leaves authorization held; failure and loss drop it
    a_event_auth: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result.auth_event == EV_SUCCESS) && result.is_authorized)
            || ((result.auth_event == EV_FAILED) && !result.is_authorized)
            || ((result.auth_event == EV_LOST) && !result.is_authorized
                && !result.new_uid_seen)
            || (result.auth_event == EV_NONE))
        else $error("event inconsistent with authorization");

endmodule

bind nfc_credential_presence_auth ncpa_checker u_ncpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .poll_valid   (poll_valid),
    .poll_ready   (poll_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### verif/ncpa_auth_checker.sv
// Checker for the NFC credential presence authorization block: tracks register writes,
// predicts one result per accepted poll and compares each accepted result in order.
// Depends on ncpa_pkg for the transaction structs, register indexes and event codes.
module ncpa_auth_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            poll_valid,
    input  logic                            poll_ready,
    input  ncpa_pkg::poll_t                 poll,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  ncpa_pkg::result_t               result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  ncpa_pkg::cfg_index_t            cfg_index,
    input  logic [ncpa_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import ncpa_pkg::*;

    logic                  op_en;
    logic [UID_W-1:0]      auth_uid;
    logic [AUTH_LEN_W-1:0] auth_len;
    logic [TIME_W-1:0]     grace_ms;

    logic                  card_present;
    logic                  held;
    logic                  held_stamped;
    logic [TIME_W-1:0]     auth_stamp_ms;
    logic [TIME_W-1:0]     card_stamp_ms;
    logic [UID_W-1:0]      last_uid;
    logic [AUTH_LEN_W-1:0] last_len;

    result_t               pending_results[$];

    function automatic logic [UID_W-1:0] low_bytes(input logic [UID_LEN_W-1:0] n);
        if (int'(n) >= UID_W / 8)
            return '1;
        return (UID_W'(1) << (8 * int'(n))) - UID_W'(1);
    endfunction

    function automatic result_t judge_poll(input poll_t p);
        result_t          r;
        logic [UID_W-1:0] m;
        logic [UID_W-1:0] cur;
        logic             fresh;
        logic             matched;
        logic             was_held;
        r = '0;
        r.auth_event = EV_NONE;
        if (!op_en)
        begin
            held = 1'b0;
            return r;
        end
        if (p.card_detected && p.uid_length != '0 && p.uid_length <= UID_LEN_MAX)
        begin
            m = low_bytes(p.uid_length);
            cur = p.uid_bytes & m;
            fresh = !card_present ||
                    !(p.uid_length == UID_LEN_W'(last_len) && cur == (last_uid & m));
            matched = (p.uid_length == UID_LEN_W'(auth_len)) && (cur == (auth_uid & m));
            card_present = 1'b1;
            card_stamp_ms = p.now_ms;
            if (fresh)
            begin
                last_uid = cur;
                last_len = p.uid_length[AUTH_LEN_W-1:0];
            end
            if (matched)
            begin
                auth_stamp_ms = p.now_ms;
                held_stamped = 1'b1;
                if (!held)
                begin
                    held = 1'b1;
                    r.auth_event = EV_SUCCESS;
                end
            end
            else
            begin
                was_held = held;
                held = 1'b0;
                held_stamped = 1'b0;
                if (fresh || was_held)
                    r.auth_event = EV_FAILED;
            end
            r.new_uid_seen = fresh;
        end
        else
        begin
            if (card_present && TIME_W'(p.now_ms - card_stamp_ms) >= grace_ms)
            begin
                card_present = 1'b0;
                last_len = '0;
            end
            if (held && held_stamped && TIME_W'(p.now_ms - auth_stamp_ms) >= grace_ms)
            begin
                held = 1'b0;
                held_stamped = 1'b0;
                r.auth_event = EV_LOST;
            end
        end
        r.is_authorized = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            op_en = 1'b0;
            auth_uid = '0;
            auth_len = AUTH_LEN_RESET;
            grace_ms = GRACE_MS_RESET;
            card_present = 1'b0;
            held = 1'b0;
            held_stamped = 1'b0;
            auth_stamp_ms = '0;
            card_stamp_ms = '0;
            last_uid = '0;
            last_len = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_READER_OPERATIONAL:    op_en = cfg_data[0];
                    CFG_AUTHORIZED_UID:        auth_uid = cfg_data[UID_W-1:0];
                    CFG_AUTHORIZED_UID_LENGTH: auth_len = cfg_data[AUTH_LEN_W-1:0];
                    CFG_GRACE_PERIOD_MS:       grace_ms = cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no poll outstanding: %p", result);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.is_authorized !== want.is_authorized)
                    begin
                        $error("is_authorized: expected %0d, got %0d",
                               want.is_authorized, result.is_authorized);
                        mismatches++;
                    end
                    if (result.auth_event !== want.auth_event)
                    begin
                        $error("auth_event: expected %0d, got %0d",
                               want.auth_event, result.auth_event);
                        mismatches++;
                    end
                    if (result.new_uid_seen !== want.new_uid_seen)
                    begin
                        $error("new_uid_seen: expected %0d, got %0d",
                               want.new_uid_seen, result.new_uid_seen);
                        mismatches++;
                    end
                end
            end
            if (poll_valid && poll_ready)
                pending_results.push_back(judge_poll(poll));
            outstanding <= pending_results.size();
        end
    end

endmodule

### verif/nfc_credential_presence_auth_tb.sv
// Testbench top for the NFC credential presence authorization block: directed polls,
// then card sessions with random content, gaps and stalls on both channels.
// Depends on ncpa_pkg, the block itself and ncpa_auth_checker.
module nfc_credential_presence_auth_tb;
    import ncpa_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  poll_valid   = 1'b0;
    poll_t                 poll         = '0;
    logic                  result_ready = 1'b0;
    logic                  cfg_valid    = 1'b0;
    cfg_index_t            cfg_index    = CFG_READER_OPERATIONAL;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  poll_ready;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_ready;

    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles  = 0;
    bit                    hold_req     = 1'b0;
    bit                    quiet_sender = 1'b0;

    logic [TIME_W-1:0]     clock_ms     = '0;
    logic [UID_W-1:0]      cur_uid      = '0;
    logic [AUTH_LEN_W-1:0] cur_len      = AUTH_LEN_RESET;
    logic [TIME_W-1:0]     cur_grace    = GRACE_MS_RESET;

    localparam logic [UID_W-1:0] UID_A = 56'h3C96E1075BA4D2;

    always #4 clk = ~clk;

    nfc_credential_presence_auth uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ncpa_auth_checker auth_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    function automatic logic [UID_W-1:0] rand_uid();
        return UID_W'({$urandom(), $urandom()});
    endfunction

    function automatic poll_t mk_poll(input bit det, input logic [UID_LEN_W-1:0] len,
                                      input logic [UID_W-1:0] uid,
                                      input logic [TIME_W-1:0] now);
        poll_t p;
        p.card_detected = det;
        p.uid_length = len;
        p.uid_bytes = uid;
        p.now_ms = now;
        return p;
    endfunction

    task automatic send_poll(input poll_t p, input bit rush);
        int gap;
        gap = (rush || quiet_sender) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll <= p;
        do @(posedge clk); while (!poll_ready);
    endtask

    task automatic wait_idle();
        poll_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input bit op, input logic [UID_W-1:0] uid,
                              input logic [AUTH_LEN_W-1:0] len,
                              input logic [TIME_W-1:0] grace);
        wait_idle();
        write_reg(CFG_READER_OPERATIONAL, CFG_DATA_W'(op));
        write_reg(CFG_AUTHORIZED_UID, uid);
        write_reg(CFG_AUTHORIZED_UID_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_GRACE_PERIOD_MS, CFG_DATA_W'(grace));
        cfg_valid <= 1'b0;
        cur_uid = uid;
        cur_len = len;
        cur_grace = grace;
    endtask

    task automatic run_sessions(input int n);
        int                   sent;
        int                   kind;
        int                   pick;
        int                   bitpos;
        logic [UID_LEN_W-1:0] len;
        logic [UID_W-1:0]     uid;
        logic [UID_W-1:0]     u;
        logic [TIME_W-1:0]    d;
        poll_t                p;
        sent = 0;
        while (sent < n)
        begin
            quiet_sender = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (cur_len != '0 && kind < 6)
                len = UID_LEN_W'(cur_len);
            else
                len = UID_LEN_W'($urandom_range(1, UID_BYTES));
            uid = (kind < 7) ? cur_uid : rand_uid();
            if (kind == 5)
            begin
                bitpos = $urandom_range(0, 8 * int'(len) - 1);
                uid[bitpos] = ~uid[bitpos];
            end
            repeat ($urandom_range(1, 6))
            begin
                clock_ms += TIME_W'($urandom_range(0, 300));
                u = rand_uid();
                for (int b = 0; b < int'(len); b++)
                    u[b*8 +: 8] = uid[b*8 +: 8];
                p = mk_poll(1'b1, len, u, clock_ms);
                if ($urandom_range(0, 7) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: p.card_detected = 1'b0;
                        1: p.uid_length = $urandom_range(0, 1) ? 4'd0
                                                               : 4'($urandom_range(8, 15));
                        default: p = mk_poll(1'($urandom()), 4'($urandom()), rand_uid(),
                                             $urandom());
                    endcase
                end
                send_poll(p, 1'b0);
                sent++;
            end
            repeat ($urandom_range(0, 4))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    d = TIME_W'($urandom_range(0, 400));
                else if (pick < 9)
                    d = cur_grace - 2 + TIME_W'($urandom_range(0, 3));
                else
                    d = $urandom();
                clock_ms += d;
                p = mk_poll(1'b0, 4'($urandom()), rand_uid(), clock_ms);
                if ($urandom_range(0, 2) == 0)
                begin
                    p.card_detected = 1'b1;
                    p.uid_length = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(8, 15));
                end
                send_poll(p, 1'b0);
                sent++;
            end
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin
        int stall;
        int calm_left;
        calm_left = 0;
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_OFF_CYCLES;
                hold_req = 1'b0;
            end
            else if (calm_left > 0)
            begin
                stall = 0;
                calm_left--;
            end
            else
            begin
                stall = $urandom_range(0, 6);
                if ($urandom_range(0, 24) == 0)
                    calm_left = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin
        if ((poll_valid && poll_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("nfc_credential_presence_auth_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reader not yet operational
        send_poll(mk_poll(1'b1, 4'd4, '0, 32'd10), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, 56'hFFFFFF00000000, 32'd20), 1'b0);

        set_config(1'b1, UID_A, 3'd4, 32'd1000);
        send_poll(mk_poll(1'b1, 4'd4, UID_A ^ 56'hFFFFFF00000000, 32'd100), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A ^ 56'h12345600000000, 32'd200), 1'b0);
        send_poll(mk_poll(1'b0, 4'd4, UID_A, 32'd900), 1'b0);
        send_poll(mk_poll(1'b1, 4'd0, UID_A, 32'd1000), 1'b0);
        send_poll(mk_poll(1'b1, 4'd8, UID_A, 32'd1099), 1'b0);
        send_poll(mk_poll(1'b1, 4'd15, UID_A, 32'd1100), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A, 32'd1200), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A ^ 56'h1, 32'd1300), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A ^ 56'h1, 32'd1400), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A, 32'd1500), 1'b0);
        send_poll(mk_poll(1'b1, 4'd3, UID_A, 32'd1600), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A, 32'd1700), 1'b0);
        send_poll(mk_poll(1'b1, 4'd4, UID_A ^ 56'h00000000800000, 32'd1800), 1'b0);

        set_config(1'b1, '1, 3'd7, 32'd0);
        send_poll(mk_poll(1'b1, 4'd7, '1, 32'hFFFFFFF0), 1'b0);
        send_poll(mk_poll(1'b0, 4'd0, '1, 32'hFFFFFFF0), 1'b0);
        send_poll(mk_poll(1'b1, 4'd7, '1, 32'h00000010), 1'b0);
        send_poll(mk_poll(1'b1, 4'd7, 56'h7FFFFFFFFFFFFF, 32'h00000020), 1'b0);

        set_config(1'b1, '0, 3'd0, 32'hFFFFFFFF);
        send_poll(mk_poll(1'b1, 4'd1, '0, 32'd50), 1'b0);
        send_poll(mk_poll(1'b1, 4'd7, '0, 32'd60), 1'b0);
        send_poll(mk_poll(1'b0, 4'd7, '0, 32'd59), 1'b0);

        set_config(1'b1, '0, 3'd7, 32'hFFFFFFFF);
        send_poll(mk_poll(1'b1, 4'd7, '0, 32'd5), 1'b0);
        send_poll(mk_poll(1'b0, 4'd0, '0, 32'd4), 1'b0);

        set_config(1'b0, UID_A, 3'd4, 32'd1000);
        send_poll(mk_poll(1'b1, 4'd4, UID_A, 32'd7), 1'b0);

        clock_ms = $urandom();
        set_config(1'b1, rand_uid(), 3'd4, 32'd1000);
        run_sessions(250);
        set_config(1'b1, rand_uid(), 3'd7, TIME_W'($urandom_range(0, 5000)));
        run_sessions(250);
        set_config(1'b1, rand_uid(), 3'd1, 32'd0);
        run_sessions(120);
        set_config(1'b1, rand_uid(), 3'd0, 32'hFFFFFFFF);
        run_sessions(120);
        set_config(1'b1, rand_uid(), 3'($urandom_range(1, 7)), 32'd2000);
        run_sessions(150);

        // drop the reader with state in place, then bring it back
        set_config(1'b0, cur_uid, cur_len, cur_grace);
        run_sessions(80);
        set_config(1'b1, cur_uid, cur_len, cur_grace);
        run_sessions(80);

        // hold the result side and keep offering polls
        hold_req = 1'b1;
        repeat (16)
        begin
            clock_ms += 32'd5;
            send_poll(mk_poll(1'b1, UID_LEN_W'(cur_len), cur_uid, clock_ms), 1'b1);
        end
        wait_idle();
        run_sessions(150);

        set_config(1'b1, rand_uid(), 3'($urandom_range(1, 7)),
                   TIME_W'($urandom_range(0, 3000)));
        run_sessions(150);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("nfc_credential_presence_auth_tb: clean");
        else
            $display("nfc_credential_presence_auth_tb: errors");
        $finish;
    end

endmodule
